@@ rtl/core/bmd_pkg.sv @@
package bmd_pkg;

    // pixel and pair sum layout
    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;
    localparam int SUM_W  = CH_W + 1;
    localparam int PAIR_W = NUM_CH * SUM_W;

    // configuration port
    localparam int CFG_W  = 10;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 10'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 10'd512;

    // default image limits
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [PAIR_W-1:0] pair_t;

    // per-channel sum of two horizontally adjacent pixels
    function automatic pair_t pair_sum(pixel_t a, pixel_t b);
        pair_t r;
        r = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            r[c*SUM_W +: SUM_W] = SUM_W'(a[c*CH_W +: CH_W]) + SUM_W'(b[c*CH_W +: CH_W]);
        end
        return r;
    endfunction

    // rounded mean of top and bottom pair sums, per channel
    function automatic pixel_t combine(pair_t top, pair_t bottom);
        logic [SUM_W:0] s;
        pixel_t         r;
        r = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            s = (SUM_W+1)'(top[c*SUM_W +: SUM_W]) + (SUM_W+1)'(bottom[c*SUM_W +: SUM_W])
                + (SUM_W+1)'(2);
            r[c*CH_W +: CH_W] = s[SUM_W:2];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bmd_ram.sv @@
module bmd_ram #(
    parameter int DATA_W = bmd_pkg::PAIR_W,
    parameter int DEPTH  = bmd_pkg::DEF_MAX_WIDTH / 2
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                      wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/box_mip_downsample.sv @@
// 2x2 box-filter mip downsampler. Source pixels (four 8-bit channels, channel c in bits
// 8c+7..8c) enter in raster order on the s_ stream; one pixel of the next mip level leaves
// on the m_ stream per 2x2 block, each channel (sum + 2) / 4, with m_tlast on the final
// pixel of the level. Odd trailing columns and rows are dropped, a dimension of one is
// used twice, a size of zero acts as one and a size above MAX_WIDTH / MAX_HEIGHT is
// clamped. The block takes one pixel per clock unless the output stalls; the pixel that
// ends a block goes to the stage-one register while the line store (MAX_WIDTH/2 entries
// of 36-bit pair sums in one RAM) is read, then to the output register. Any register write
// restarts the frame at the top-left pixel; write registers only while the block is idle.
module box_mip_downsample #(
    parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmd_pkg::APB_AW-1:0]  paddr,
    input  logic [bmd_pkg::APB_DW-1:0]  pwdata,
    output logic [bmd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // source pixels
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bmd_pkg::PIX_W-1:0]   s_tdata,   // pixel_in
    // downsampled pixels
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bmd_pkg::PIX_W-1:0]   m_tdata,   // pixel_out
    output logic                        m_tlast    // level_done
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LA_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [bmd_pkg::CFG_W-1:0] width_reg, width_next;
    logic [bmd_pkg::CFG_W-1:0] height_reg, height_next;
    logic                      cfg_wr;

    // frame position and held left pixel
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    bmd_pkg::pixel_t      held_reg, held_next;

    // stage one: pair sum waiting for the line store read
    logic                 s1_valid_reg, s1_valid_next;
    bmd_pkg::pair_t       s1_pair_reg, s1_pair_next;
    logic                 s1_self_reg, s1_self_next;
    logic                 s1_last_reg, s1_last_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    bmd_pkg::pixel_t      m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    logic [31:0]          w_cfg32, h_cfg32, w_eff32, h_eff32;
    logic [WW-1:0]        w_eff, ow;
    logic [HW-1:0]        h_eff, oh;
    logic [CW-1:0]        ox;
    logic [RW-1:0]        oy;
    logic                 is_w1, is_h1;
    logic                 col_last, row_last, row_has_next;
    logic                 ox_last, oy_last, in_line;
    logic                 pair_ready, emit;
    logic                 s_acc, s1_adv;
    logic                 mem_we, mem_re;
    bmd_pkg::pair_t       pair, line_rdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            case (bmd_pkg::reg_idx_t'(paddr[2]))
                bmd_pkg::REG_SRC_WIDTH:  width_next  = pwdata[bmd_pkg::CFG_W-1:0];
                bmd_pkg::REG_SRC_HEIGHT: height_next = pwdata[bmd_pkg::CFG_W-1:0];
                default:                 width_next  = width_reg;
            endcase
        end
    end

    always_comb begin
        case (bmd_pkg::reg_idx_t'(paddr[2]))
            bmd_pkg::REG_SRC_WIDTH:  prdata = bmd_pkg::APB_DW'(width_reg);
            bmd_pkg::REG_SRC_HEIGHT: prdata = bmd_pkg::APB_DW'(height_reg);
            default:                 prdata = '0;
        endcase
    end

    // effective image size, clamped to one .. limit
    always_comb begin
        w_cfg32 = 32'(width_reg);
        h_cfg32 = 32'(height_reg);
        if (w_cfg32 == 32'd0) begin
            w_eff32 = 32'd1;
        end else if (w_cfg32 > 32'(MAX_WIDTH)) begin
            w_eff32 = 32'(MAX_WIDTH);
        end else begin
            w_eff32 = w_cfg32;
        end
        if (h_cfg32 == 32'd0) begin
            h_eff32 = 32'd1;
        end else if (h_cfg32 > 32'(MAX_HEIGHT)) begin
            h_eff32 = 32'(MAX_HEIGHT);
        end else begin
            h_eff32 = h_cfg32;
        end
    end

    assign w_eff = w_eff32[WW-1:0];
    assign h_eff = h_eff32[HW-1:0];
    assign is_w1 = (w_eff == WW'(1));
    assign is_h1 = (h_eff == HW'(1));
    assign ow    = is_w1 ? WW'(1) : (w_eff >> 1);
    assign oh    = is_h1 ? HW'(1) : (h_eff >> 1);

    // position decode
    assign ox           = col_reg >> 1;
    assign oy           = row_reg >> 1;
    assign col_last     = (WW'(col_reg) + WW'(1)) == w_eff;
    assign row_last     = (HW'(row_reg) + HW'(1)) == h_eff;
    assign row_has_next = (HW'(row_reg) + HW'(1)) < h_eff;
    assign ox_last      = (WW'(ox) + WW'(1)) == ow;
    assign oy_last      = (HW'(oy) + HW'(1)) == oh;
    assign in_line      = 32'(ox) < 32'(LINE_DEPTH);

    // horizontal pair
    assign pair_ready = is_w1 || col_reg[0];
    assign pair       = bmd_pkg::pair_sum(is_w1 ? s_tdata : held_reg, s_tdata);
    assign emit       = pair_ready && in_line && (is_h1 || row_reg[0]);

    // handshakes
    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    // line store: even rows write pair sums, odd rows read them back
    assign mem_we = s_acc && pair_ready && in_line && !is_h1 && !row_reg[0] && row_has_next;
    assign mem_re = s_acc && emit && !is_h1;

    bmd_ram #(
        .DATA_W (bmd_pkg::PAIR_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (ox[LA_W-1:0]),
        .wdata (pair),
        .re    (mem_re),
        .raddr (ox[LA_W-1:0]),
        .rdata (line_rdata)
    );

    // frame position and held pixel
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (cfg_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (s_acc) begin
            if (!is_w1 && !col_reg[0]) begin
                held_next = s_tdata;
            end
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // stage one
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_pair_next  = s1_pair_reg;
        s1_self_next  = s1_self_reg;
        s1_last_next  = s1_last_reg;
        if (s_acc) begin
            s1_valid_next = emit;
            s1_pair_next  = pair;
            s1_self_next  = is_h1;
            s1_last_next  = is_h1 ? ox_last : (ox_last && oy_last);
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (s1_valid_reg && s1_adv) begin
            m_valid_next = 1'b1;
            m_data_next  = bmd_pkg::combine(s1_self_reg ? s1_pair_reg : line_rdata,
                                            s1_pair_reg);
            m_last_next  = s1_last_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= bmd_pkg::WIDTH_RST;
            height_reg   <= bmd_pkg::HEIGHT_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            held_reg     <= held_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_pair_reg <= s1_pair_next;
        s1_self_reg <= s1_self_next;
        s1_last_reg <= s1_last_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/core/bmd_checker.sv @@
module bmd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bmd_pkg::APB_AW-1:0]  paddr,
    input logic [bmd_pkg::APB_DW-1:0]  pwdata,
    input logic [bmd_pkg::APB_DW-1:0]  prdata,
    input logic                        pready,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bmd_pkg::PIX_W-1:0]   m_tdata,
    input logic                        m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a fresh result follows a completed input transaction
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input transaction");

    // width register reads back what was written
    a_width_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        ##1 (psel && !pwrite && paddr[2] == 1'b0)
        |-> prdata[bmd_pkg::CFG_W-1:0] == $past(pwdata[bmd_pkg::CFG_W-1:0]))
        else $error("width register readback mismatch");

endmodule

bind box_mip_downsample bmd_checker u_bmd_checker (.*);
